// ----- rtl/mfh_pkg.sv -----
package mfh_pkg;

  // Width of the thread identifier field on the request and result channels.
  localparam int unsigned TidFieldW = 8;

  typedef logic [TidFieldW-1:0] tid_field_t;

  // Operation codes carried in the request.
  localparam logic [1:0] OP_LOCK   = 2'd0;
  localparam logic [1:0] OP_TRY    = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;

  // Status codes returned in the result.
  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_BUSY    = 3'd1;
  localparam logic [2:0] STATUS_QUEUED  = 3'd2;
  localparam logic [2:0] STATUS_HANDOFF = 3'd3;
  localparam logic [2:0] STATUS_FULL    = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    tid_field_t thread_id;
  } mfh_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       grant_valid;
    tid_field_t granted_thread;
  } mfh_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } mfh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } mfh_sts_t;

endpackage

// ----- rtl/mutex_fifo_handoff_unit.sv -----
// Hardware mutex with a first-in first-out queue of waiting threads.
//
// Requests arrive on the in_* channel as one transaction each, carrying an
// operation (lock, try lock or unlock) and a thread identifier. Every request
// produces exactly one result transaction on the out_* channel with a status,
// a grant flag and, on a handoff, the thread that now owns the lock.
// Both channels use valid and stall: a transaction moves on a rising edge
// where valid is high and stall is low.
//
// A request is captured first; then, once the result register is free, the
// head of the wait queue (read from a registered memory port) is ready and
// the decision is committed into the result register. No new request is
// taken until the current one is committed. While the receiver stalls, the
// result is held and the next request is still accepted and captured; it is
// resolved as soon as the waiting result leaves.
//
// Reset frees the lock and empties the queue; the queue storage itself is not
// cleared, as only written entries are ever used.
module mutex_fifo_handoff_unit #(
  parameter int unsigned WAIT_DEPTH  = 16,
  parameter int unsigned THREAD_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mfh_pkg::mfh_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mfh_pkg::mfh_rsp_t out_data_o
);
  import mfh_pkg::*;

  // Command and status between the sequencing controller and the datapath
  // that holds the owner register, the queue pointers and the queue memory.
  mfh_cmd_t cmd;
  mfh_sts_t sts;

  mfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfh_datapath #(
    .WAIT_DEPTH  (WAIT_DEPTH),
    .THREAD_BITS (THREAD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- rtl/mfh_ctrl.sv -----
module mfh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mfh_pkg::mfh_sts_t sts_i,
  output mfh_pkg::mfh_cmd_t cmd_o
);
  import mfh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // The request is resolved once the result register can take it.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/mfh_datapath.sv -----
module mfh_datapath #(
  parameter int unsigned WAIT_DEPTH  = 16,
  parameter int unsigned THREAD_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfh_pkg::mfh_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mfh_pkg::mfh_rsp_t out_data_o,
  input  mfh_pkg::mfh_cmd_t cmd_i,
  output mfh_pkg::mfh_sts_t sts_o
);
  import mfh_pkg::*;

  localparam int unsigned TidW = (THREAD_BITS < TidFieldW) ? THREAD_BITS : TidFieldW;
  localparam int unsigned PtrW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(WAIT_DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(WAIT_DEPTH - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(WAIT_DEPTH);

  mfh_req_t            req_q;
  logic                owner_valid_q, owner_valid_d;
  logic [TidW-1:0]     owner_q, owner_d;
  logic [PtrW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [TidW-1:0]     wait_mem [WAIT_DEPTH];
  logic [TidW-1:0]     head_rd_q;
  logic                wr_en;
  logic [TidW-1:0]     tid;
  logic                out_valid_q;
  mfh_rsp_t            out_q, rsp;

  assign tid = req_q.thread_id[TidW-1:0];
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    owner_valid_d = owner_valid_q;
    owner_d       = owner_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    wr_en         = 1'b0;
    rsp           = '0;
    rsp.status    = STATUS_BUSY;
    case (req_q.operation)
      OP_LOCK: begin
        if (!owner_valid_q) begin
          owner_valid_d = 1'b1;
          owner_d       = tid;
          rsp.status    = STATUS_OK;
        end else if (owner_q == tid) begin
          rsp.status = STATUS_OK;
        end else if (count_q == FullCount) begin
          rsp.status = STATUS_FULL;
        end else begin
          wr_en      = 1'b1;
          tail_d     = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
          count_d    = count_q + 1'b1;
          rsp.status = STATUS_QUEUED;
        end
      end
      OP_TRY: begin
        if (!owner_valid_q) begin
          owner_valid_d = 1'b1;
          owner_d       = tid;
          rsp.status    = STATUS_OK;
        end
      end
      OP_UNLOCK: begin
        if (!owner_valid_q) begin
          rsp.status = STATUS_OK;
        end else if (count_q == '0) begin
          owner_valid_d = 1'b0;
          owner_d       = '0;
          rsp.status    = STATUS_OK;
        end else begin
          owner_d            = head_rd_q;
          head_d             = (head_q == LastSlot) ? '0 : head_q + 1'b1;
          count_d            = count_q - 1'b1;
          rsp.status         = STATUS_HANDOFF;
          rsp.grant_valid    = 1'b1;
          rsp.granted_thread = tid_field_t'(head_rd_q);
        end
      end
      default: begin
        rsp.status = STATUS_BUSY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_valid_q <= 1'b0;
      owner_q       <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        owner_valid_q <= owner_valid_d;
        owner_q       <= owner_d;
        head_q        <= head_d;
        tail_q        <= tail_d;
        count_q       <= count_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= rsp;
    end
  end

  // Waiting queue storage; the head entry is read every cycle so that it is
  // ready in the cycle after a request is captured.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      wait_mem[tail_q] <= tid;
    end
    head_rd_q <= wait_mem[head_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/mfh_checker.sv -----
module mfh_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input mfh_pkg::mfh_req_t in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mfh_pkg::mfh_rsp_t out_data_o
);
  import mfh_pkg::*;

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // The grant flag is raised exactly for a handoff.
  a_grant_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.grant_valid == (out_data_o.status == STATUS_HANDOFF)))
    else $error("grant flag does not match handoff status");

  // A result without a grant names no thread.
  a_no_grant_thread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.grant_valid) |-> (out_data_o.granted_thread == '0))
    else $error("thread named on a result without a grant");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind mutex_fifo_handoff_unit mfh_checker u_mfh_checker (.*);
